@@ hw/rtl/swm_pkg.sv @@
package swm_pkg;

   localparam int SAMPLE_W         = 32;
   localparam int CFG_W            = 7;
   localparam int WINDOW_MAX_DEF   = 64;
   localparam int WINDOW_LEN_RESET = 5;

   typedef logic signed [SAMPLE_W-1:0] sample_type;

   // Control broadcast to every cell of the sorted chain.
   typedef struct packed {
      logic       step;    // apply one insert/remove this cycle
      logic       grow;    // window not yet full: no sample leaves
      logic       rem_en;  // window full: remove the oldest sample
      logic       clear;   // empty the chain
      sample_type key;     // sample entering the window
      sample_type ov;      // sample leaving the window
   } chain_ctrl_type;

   // What one cell shows to its neighbors.
   typedef struct packed {
      logic       valid;   // cell holds a sample
      sample_type value;   // held sample
      logic       gt;      // held sample sorts after the key
      sample_type r_value; // sample at this place once the oldest is removed
      logic       r_gt;    // r_value sorts after the key
   } cell_link_type;

endpackage

@@ hw/rtl/swm_req_if.sv @@
interface swm_req_if;
   logic                valid;
   logic                ready;
   swm_pkg::sample_type sample;

   modport source (output valid, output sample, input ready);
   modport sink (input valid, input sample, output ready);
endinterface

@@ hw/rtl/swm_rsp_if.sv @@
interface swm_rsp_if;
   logic                valid;
   logic                ready;
   swm_pkg::sample_type median;

   modport source (output valid, output median, input ready);
   modport sink (input valid, input median, output ready);
endinterface

@@ hw/rtl/swm_csr_if.sv @@
interface swm_csr_if;
   logic                        valid;
   logic                        ready;
   logic [swm_pkg::CFG_W-1:0]   window_len;

   modport source (output valid, output window_len, input ready);
   modport sink (input valid, input window_len, output ready);
endinterface

@@ hw/rtl/swm_ram.sv @@
module swm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/swm_cell.sv @@
module swm_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  swm_pkg::chain_ctrl_type ctrl,
   input  swm_pkg::cell_link_type  left_link,
   input  swm_pkg::cell_link_type  right_link,
   output swm_pkg::cell_link_type  own_link
);

   logic                valid_ff;
   logic                valid_in;
   swm_pkg::sample_type value_ff;
   swm_pkg::sample_type value_in;
   logic                gt;
   logic                del;
   swm_pkg::sample_type r_value;
   logic                r_gt;

   always_comb begin
      gt      = !valid_ff || ($signed(value_ff) > $signed(ctrl.key));
      // at or above the removal point: take the right neighbor's sample
      del     = ctrl.rem_en && (!valid_ff || ($signed(value_ff) >= $signed(ctrl.ov)));
      r_value = del ? right_link.value : value_ff;
      r_gt    = del ? right_link.gt : gt;

      priority if (!r_gt) begin
         value_in = r_value;
      end else if (left_link.r_gt) begin
         value_in = left_link.r_value;
      end else begin
         value_in = ctrl.key;
      end

      valid_in = ctrl.grow ? (valid_ff | left_link.valid) : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset || ctrl.clear) begin
         valid_ff <= 1'b0;
      end else if (ctrl.step) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.step) begin
         value_ff <= value_in;
      end
   end

   assign own_link.valid   = valid_ff;
   assign own_link.value   = value_ff;
   assign own_link.gt      = gt;
   assign own_link.r_value = r_value;
   assign own_link.r_gt    = r_gt;

endmodule

@@ hw/rtl/swm_chain.sv @@
module swm_chain #(
   parameter int CELLS = swm_pkg::WINDOW_MAX_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  swm_pkg::chain_ctrl_type ctrl,
   output swm_pkg::sample_type     cell_value [CELLS]
);

   swm_pkg::cell_link_type links [CELLS];
   swm_pkg::cell_link_type low_end;
   swm_pkg::cell_link_type high_end;

   // below cell 0: always filled, never sorts after the key
   assign low_end.valid   = 1'b1;
   assign low_end.value   = '0;
   assign low_end.gt      = 1'b0;
   assign low_end.r_value = '0;
   assign low_end.r_gt    = 1'b0;

   // above the last cell: empty, sorts after everything
   assign high_end.valid   = 1'b0;
   assign high_end.value   = '0;
   assign high_end.gt      = 1'b1;
   assign high_end.r_value = '0;
   assign high_end.r_gt    = 1'b1;

   for (genvar i = 0; i < CELLS; i++) begin : g_cell
      swm_pkg::cell_link_type left_link;
      swm_pkg::cell_link_type right_link;

      if (i == 0) begin : g_lo
         assign left_link = low_end;
      end else begin : g_lo_n
         assign left_link = links[i-1];
      end

      if (i == CELLS - 1) begin : g_hi
         assign right_link = high_end;
      end else begin : g_hi_n
         assign right_link = links[i+1];
      end

      swm_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .left_link  (left_link),
         .right_link (right_link),
         .own_link   (links[i])
      );

      assign cell_value[i] = links[i].value;
   end

endmodule

@@ hw/rtl/sliding_window_median.sv @@
// Sliding window median filter.
//
// req_bus (sink) carries one signed 32-bit sample per beat. rsp_bus (source)
// carries the lower median of the last window_len samples, one beat per sample
// once the window is full; the first window_len-1 samples give no beat.
// csr_bus (sink) writes window_len (0 acts as 1, values above WINDOW_MAX act as
// WINDOW_MAX); a write empties the window. csr_bus.ready is always high.
//
// Steps: a sample that gives no result passes accept and chain update; one that
// does also passes median select into the output register. rsp_bus.valid rises
// when that register loads, after the accept and chain update steps. The update
// step uses the arrival ring's registered read of the leaving sample and the one
// shared update step of the sorted cell chain.
//
// Reset: window_len returns to 5 and the window is empty; no clearing pass.
// Stall: a waiting result sits in the output register while the next sample is
// taken; a second result holds in the select step until rsp_bus.ready.
module sliding_window_median #(
   parameter int WINDOW_MAX = swm_pkg::WINDOW_MAX_DEF
) (
   input logic  clock,
   input logic  reset,
   swm_req_if.sink   req_bus,
   swm_rsp_if.source rsp_bus,
   swm_csr_if.sink   csr_bus
);

   localparam int LW = $clog2(WINDOW_MAX + 1);                  // count width
   localparam int IW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1; // index width
   localparam int WW = (LW > swm_pkg::CFG_W) ? LW : swm_pkg::CFG_W;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_UPD  = 2'd1;
   localparam logic [1:0] ST_OUT  = 2'd2;

   logic [1:0]                state_ff, state_in;
   logic [swm_pkg::CFG_W-1:0] len_ff;
   logic [LW-1:0]             fill_ff, fill_in;
   logic [IW-1:0]             ptr_ff, ptr_in;
   swm_pkg::sample_type       key_ff;
   logic                      rsp_valid_ff, rsp_valid_in;
   swm_pkg::sample_type       rsp_median_ff;

   logic [WW-1:0]             len_wide;
   logic [LW-1:0]             len_eff;
   logic [LW-1:0]             med_idx;
   logic                      full;
   logic                      req_take;
   logic                      csr_take;
   logic                      rsp_load;
   logic                      ram_wr_en;
   logic [IW-1:0]             ram_wr_addr;
   logic [swm_pkg::SAMPLE_W-1:0] ram_rd_data;
   swm_pkg::chain_ctrl_type   ctrl;
   swm_pkg::sample_type       cell_value [WINDOW_MAX];

   // effective window length: zero acts as one, saturate at WINDOW_MAX
   always_comb begin
      len_wide = WW'(len_ff);
      priority if (len_ff == '0) begin
         len_eff = LW'(1);
      end else if (len_wide > WW'(WINDOW_MAX)) begin
         len_eff = LW'(WINDOW_MAX);
      end else begin
         len_eff = LW'(len_wide);
      end
   end

   assign full    = (fill_ff == len_eff);
   assign med_idx = (len_eff - LW'(1)) >> 1;

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign req_take      = req_bus.valid && req_bus.ready;
   assign csr_bus.ready = 1'b1;
   assign csr_take      = csr_bus.valid;
   assign rsp_load      = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_bus.ready);

   // Arrival ring: write the new sample into the slot of the leaving one
   // (or the next free slot while filling); read the oldest slot every cycle,
   // so the read registered at the accept edge is the leaving sample.
   assign ram_wr_en   = (state_ff == ST_UPD);
   assign ram_wr_addr = full ? ptr_ff : fill_ff[IW-1:0];

   swm_ram #(
      .WIDTH (swm_pkg::SAMPLE_W),
      .DEPTH (WINDOW_MAX)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (key_ff),
      .rd_addr (ptr_ff),
      .rd_data (ram_rd_data)
   );

   // Sorted chain: one step inserts the new sample and, once full, removes the leaving one.
   assign ctrl.step   = (state_ff == ST_UPD);
   assign ctrl.grow   = !full;
   assign ctrl.rem_en = full;
   assign ctrl.clear  = csr_take;
   assign ctrl.key    = key_ff;
   assign ctrl.ov     = $signed(ram_rd_data);

   swm_chain #(
      .CELLS (WINDOW_MAX)
   ) u_chain (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .cell_value (cell_value)
   );

   always_comb begin
      state_in = state_ff;
      fill_in  = fill_ff;
      ptr_in   = ptr_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = ST_UPD;
            end
         end
         ST_UPD: begin
            if (full) begin
               // advance the oldest slot, wrap at the window length
               ptr_in  = (LW'(ptr_ff) + LW'(1) == len_eff) ? '0 : ptr_ff + IW'(1);
               fill_in = fill_ff;
            end else begin
               ptr_in  = '0;
               fill_in = fill_ff + LW'(1);
            end
            state_in = (fill_in == len_eff) ? ST_OUT : ST_IDLE;
         end
         ST_OUT: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      priority if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len_ff       <= swm_pkg::CFG_W'(swm_pkg::WINDOW_LEN_RESET);
         fill_ff      <= '0;
         ptr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_take) begin
            // new length: drop the window
            len_ff  <= csr_bus.window_len;
            fill_ff <= '0;
            ptr_ff  <= '0;
         end else begin
            fill_ff <= fill_in;
            ptr_ff  <= ptr_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         key_ff <= req_bus.sample;
      end
      if (rsp_load) begin
         rsp_median_ff <= cell_value[med_idx[IW-1:0]];
      end
   end

   assign rsp_bus.valid  = rsp_valid_ff;
   assign rsp_bus.median = rsp_median_ff;

   // the window never holds more samples than its length
   a_fill_bound : assert property (@(posedge clock) disable iff (reset)
      fill_ff <= len_eff)
      else $error("fill count above window length");

   // the oldest slot stays inside the window
   a_ptr_bound : assert property (@(posedge clock) disable iff (reset)
      LW'(ptr_ff) < len_eff)
      else $error("oldest pointer outside window");

   // a new result is only loaded from a full window
   a_rsp_full : assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> full)
      else $error("result from a window that is not full");

   // the chain steps only for an accepted sample
   a_step_after_take : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPD) |-> $past(req_take))
      else $error("chain update without an accepted sample");

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
   import swm_pkg::*;

   localparam int         LEN_MAX     = WINDOW_MAX_DEF;
   localparam int         STALL_LIMIT = 5000;  // cycles with no beat on any channel
   localparam int         DRAIN_WAIT  = 4;     // settle time for trailing samples before a length write
   localparam int         HOLD_OFF    = 300;   // long receiver hold in the pressure test
   localparam sample_type SAMPLE_MIN  = {1'b1, {(SAMPLE_W-1){1'b0}}};
   localparam sample_type SAMPLE_MAX  = {1'b0, {(SAMPLE_W-1){1'b1}}};

   logic clock;
   logic reset;

   swm_req_if req_bus ();
   swm_rsp_if rsp_bus ();
   swm_csr_if csr_bus ();

   sliding_window_median #(
      .WINDOW_MAX (LEN_MAX)
   ) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // Window predictor: the last samples in arrival order, the same samples
   // kept sorted, and the programmed length.
   logic [CFG_W-1:0] window_len_reg = CFG_W'(WINDOW_LEN_RESET);
   sample_type       arrival_ring [LEN_MAX];
   sample_type       sorted_window [$];
   int unsigned      fill_count     = 0;
   int unsigned      oldest_slot    = 0;

   // Medians still owed by the block, oldest first.
   sample_type       expected_medians [$];

   int               err_count       = 0;
   int               samples_sent    = 0;
   int               medians_checked = 0;
   int               len_writes      = 0;

   bit               no_gaps         = 1'b0;  // run both sides without idle cycles
   int               rsp_hold_req    = 0;     // receiver hold-off length, 0 = none

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Length of a gap or a stall: mostly none or short, now and then long.
   function automatic int pick_gap();
      int roll;
      if (no_gaps)
         return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55)
         return 0;
      if (roll < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Zero acts as one, anything above the maximum saturates.
   function automatic int unsigned effective_len();
      if (window_len_reg == '0)
         return 1;
      if (window_len_reg > LEN_MAX)
         return LEN_MAX;
      return window_len_reg;
   endfunction

   // Enter one sample into the predicted window; queue the median when the
   // window is full.
   task automatic window_admit(input sample_type s);
      int unsigned len;
      int unsigned slot;
      int          pos;
      sample_type  leaving;
      len = effective_len();
      if (fill_count < len) begin
         arrival_ring[fill_count] = s;
         fill_count++;
         oldest_slot = 0;
      end else begin
         slot = oldest_slot % len;
         leaving = arrival_ring[slot];
         arrival_ring[slot] = s;
         oldest_slot = (slot + 1) % len;
         // drop exactly one copy of the leaving sample, even among equals
         pos = 0;
         while (pos < sorted_window.size() && sorted_window[pos] != leaving)
            pos++;
         if (pos < sorted_window.size())
            sorted_window.delete(pos);
      end
      pos = 0;
      while (pos < sorted_window.size() && sorted_window[pos] <= s)
         pos++;
      sorted_window.insert(pos, s);
      if (fill_count == len)
         expected_medians.push_back(sorted_window[(len - 1) / 2]);
   endtask

   task automatic report_mismatch(input string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      err_count++;
   endtask

   // Offer one sample after a random gap and hold it until the beat.
   task automatic send_sample(input sample_type s);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid  <= 1'b1;
      req_bus.sample <= s;
      do @(posedge clock); while (!req_bus.ready);
      window_admit(s);
      samples_sent++;
   endtask

   // Drain all owed medians, let trailing no-result samples settle, then
   // write the window length. The write empties the window.
   task automatic write_window_len(input logic [CFG_W-1:0] len);
      req_bus.valid <= 1'b0;
      while (expected_medians.size() != 0)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      csr_bus.valid      <= 1'b1;
      csr_bus.window_len <= len;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      window_len_reg = len;
      sorted_window.delete();
      fill_count  = 0;
      oldest_slot = 0;
      len_writes++;
   endtask

   // Mix of full-range values, a narrow band that repeats values, and extremes.
   function automatic sample_type random_sample();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return sample_type'($urandom);
         4, 5, 6:    return sample_type'(int'($urandom_range(0, 8)) - 4);
         7:          return SAMPLE_MAX;
         8:          return SAMPLE_MIN;
         default:    return sample_type'({1'b1, 31'($urandom_range(0, 15))});
      endcase
   endfunction

   // Window length 5 straight out of reset: extremes, sign boundary, and
   // repeated values so that a leaving sample has equal partners.
   task automatic test_reset_length();
      send_sample(SAMPLE_MIN);
      send_sample(SAMPLE_MAX);
      send_sample('0);
      send_sample(-1);
      send_sample(1);
      send_sample(SAMPLE_MAX);
      send_sample(SAMPLE_MAX);
      send_sample(SAMPLE_MIN);
      send_sample(-1);
   endtask

   // Length one, zero acting as one, and short windows full of equal values.
   task automatic test_short_windows();
      write_window_len(CFG_W'(1));
      send_sample(SAMPLE_MIN);
      send_sample(SAMPLE_MAX);
      send_sample(-1);
      write_window_len('0);
      send_sample('0);
      send_sample(SAMPLE_MAX);
      write_window_len(CFG_W'(2));
      send_sample(7);
      send_sample(7);
      send_sample(-7);
      send_sample(7);
      write_window_len(CFG_W'(4));
      send_sample(3);
      send_sample(3);
      send_sample(3);
      send_sample(-3);
      send_sample(3);
   endtask

   // Hold the receiver off for a long stretch while samples keep coming, so
   // the output fills and the input stalls.
   task automatic test_back_pressure();
      write_window_len(CFG_W'(3));
      no_gaps      = 1'b1;
      rsp_hold_req = HOLD_OFF;
      repeat (40)
         send_sample(random_sample());
      no_gaps = 1'b0;
   endtask

   // Random phases over many window lengths; the extremes come first.
   task automatic test_random_windows();
      logic [CFG_W-1:0] forced_lens [4] = '{CFG_W'(64), '1, CFG_W'(65), CFG_W'(63)};
      logic [CFG_W-1:0] len;
      int               phase;
      int               sent_here;
      int               count;
      phase = 0;
      sent_here = 0;
      while (sent_here < 780) begin
         if (phase < 4) begin
            len = forced_lens[phase];
         end else begin
            case ($urandom_range(0, 19))
               0:       len = '0;
               1:       len = CFG_W'(64);
               2:       len = CFG_W'($urandom_range(65, 127));
               3, 4:    len = CFG_W'($urandom_range(10, 40));
               default: len = CFG_W'($urandom_range(1, 9));
            endcase
         end
         write_window_len(len);
         // every fourth phase runs flat out on both sides
         no_gaps = (phase % 4 == 3);
         count = effective_len() + $urandom_range(4, 30);
         repeat (count)
            send_sample(random_sample());
         sent_here += count;
         phase++;
      end
      no_gaps = 1'b0;
   endtask

   // Receiver: random stalls, plus a requested hold-off counted here.
   initial begin
      int stall_left;
      int hold_len;
      stall_left = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_req > 0) begin
            hold_len = rsp_hold_req;
            rsp_hold_req = 0;
            rsp_bus.ready <= 1'b0;
            repeat (hold_len - 1) @(posedge clock);
         end else if (stall_left > 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_bus.ready <= 1'b1;
            if ($urandom_range(0, 99) < 30)
               stall_left = pick_gap();
         end
      end
   end

   // Compare every result beat with the oldest owed median.
   initial begin
      sample_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            if (expected_medians.size() == 0) begin
               report_mismatch($sformatf("median %0d with none owed", rsp_bus.median));
            end else begin
               want = expected_medians.pop_front();
               if (rsp_bus.median !== want)
                  report_mismatch($sformatf("median %0d, want %0d",
                                            rsp_bus.median, want));
               medians_checked++;
            end
         end
      end
   end

   // Abort when no channel moves a beat for too long.
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
             (csr_bus.valid && csr_bus.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no beat for %0d cycles, %0d medians owed",
                     idle_cycles, expected_medians.size());
            $display("FAILURE");
            $finish;
         end
      end
   end

   initial begin
      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.sample     = '0;
      csr_bus.valid      = 1'b0;
      csr_bus.window_len = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_length();
      test_short_windows();
      test_back_pressure();
      test_random_windows();

      // drain, then give trailing samples time to show any stray beat
      req_bus.valid <= 1'b0;
      while (expected_medians.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);
      if (expected_medians.size() != 0)
         report_mismatch($sformatf("%0d medians never arrived", expected_medians.size()));

      $display("Sent %0d samples over %0d window length writes (lengths 0 to 127).",
               samples_sent, len_writes);
      $display("Checked %0d medians, including a long receiver hold-off.",
               medians_checked);
      if (err_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

@@ sim.f @@
hw/rtl/swm_pkg.sv
hw/rtl/swm_req_if.sv
hw/rtl/swm_rsp_if.sv
hw/rtl/swm_csr_if.sv
hw/rtl/swm_ram.sv
hw/rtl/swm_cell.sv
hw/rtl/swm_chain.sv
hw/rtl/sliding_window_median.sv
tb/sv/testbench.sv
